// File: src/wbps_pkg.sv
package wbps_pkg;

	localparam int MAX_PATTERN = 256;
	localparam int LEN_W = 9;
	localparam int IDX_W = 8;
	localparam int BYTE_W = 8;
	localparam int POS_W = 32;
	localparam int EFF_W = $clog2(MAX_PATTERN + 1);

	typedef enum logic [1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_SCAN    = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic scan;
		logic clear;
	} cell_ctrl_t;

endpackage

// File: src/wbps_in_if.sv
interface wbps_in_if;
	import wbps_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [IDX_W-1:0]  entry_index;
	logic [BYTE_W-1:0] entry_byte;
	logic              entry_wild;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, func, entry_index, entry_byte, entry_wild, data_byte,
		input ready);
	modport sink (input valid, func, entry_index, entry_byte, entry_wild, data_byte,
		output ready);

endinterface

// File: src/wbps_out_if.sv
interface wbps_out_if;
	import wbps_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] match_start;

	modport source (output valid, match_start, input ready);
	modport sink (input valid, match_start, output ready);

endinterface

// File: src/wildcard_byte_pattern_scanner_core.sv
// Wildcard byte pattern scanner.
// Items arrive on the valid/ready channel "item": a load writes one pattern
// entry (byte and wildcard mark), a scan feeds one stream byte, a restart
// clears the scan. The first completed match sends its start offset on the
// valid/ready channel "result"; later scan bytes are ignored until a restart.
// cfg_we/cfg_wdata write the pattern length; write it only while idle.
// One item is accepted per cycle while item.ready is high: each
// pattern position is a cell of a chain that compares its entry with the
// broadcast byte and passes its partial match bit to the next cell.
// A match is registered in the output register, or in the skid register while that holds an untaken result.
// The result leaves through an output register backed by a skid register;
// item.ready falls only while both hold results the receiver has not taken.
// Reset clears the scan, the partial matches and the output stage and sets
// the length to one; pattern entries hold no reset value and must be loaded.
// The byte count saturates at its maximum.
module wildcard_byte_pattern_scanner_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [wbps_pkg::LEN_W-1:0] cfg_wdata,
	wbps_in_if.sink                    item,
	wbps_out_if.source                 result
);
	import wbps_pkg::*;

	logic [LEN_W-1:0]       len_q;
	logic [POS_W-1:0]       bytes_q;
	logic                   found_q;
	logic                   fire;
	logic                   space;
	logic                   match;
	logic                   push;
	logic [POS_W-1:0]       push_data;
	logic [EFF_W-1:0]       eff_len;
	logic [EFF_W-1:0]       eff_m1;
	cell_ctrl_t             ctrl;
	logic [MAX_PATTERN-1:0] chain;
	logic [MAX_PATTERN-1:0] end_hit;

	assign item.ready = space;
	assign fire       = item.valid & space;
	assign ctrl.scan  = fire & (item.func == FUNC_SCAN) & ~found_q;
	assign ctrl.clear = fire & (item.func == FUNC_RESTART);

	always_comb begin
		if (int'(len_q) > MAX_PATTERN) begin
			eff_len = EFF_W'(MAX_PATTERN);
		end else if (len_q == '0) begin
			eff_len = EFF_W'(1);
		end else begin
			eff_len = EFF_W'(len_q);
		end
	end
	assign eff_m1 = eff_len - EFF_W'(1);

	assign chain[0] = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic load;
		logic is_last;
		logic part;

		assign load    = fire && (item.func == FUNC_LOAD) && (int'(item.entry_index) == i);
		assign is_last = (eff_m1 == EFF_W'(i));

		wbps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.load       (load),
			.entry_byte (item.entry_byte),
			.entry_wild (item.entry_wild),
			.data_byte  (item.data_byte),
			.prev       (chain[i]),
			.is_last    (is_last),
			.part       (part),
			.end_hit    (end_hit[i])
		);

		if (i < MAX_PATTERN - 1) begin : g_link
			assign chain[i+1] = part;
		end
	end

	assign match     = |end_hit;
	assign push      = ctrl.scan & match;
	assign push_data = bytes_q - POS_W'(eff_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			bytes_q <= '0;
			found_q <= 1'b0;
		end else if (ctrl.scan) begin
			if (bytes_q != '1) begin
				bytes_q <= bytes_q + POS_W'(1);
			end
			if (match) begin
				found_q <= 1'b1;
			end
		end
	end

	wbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.result    (result)
	);

endmodule

// File: src/wbps_cell.sv
module wbps_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wbps_pkg::cell_ctrl_t       ctrl,
	input  logic                       load,
	input  logic [wbps_pkg::BYTE_W-1:0] entry_byte,
	input  logic                       entry_wild,
	input  logic [wbps_pkg::BYTE_W-1:0] data_byte,
	input  logic                       prev,
	input  logic                       is_last,
	output logic                       part,
	output logic                       end_hit
);
	import wbps_pkg::*;

	logic [BYTE_W-1:0] byte_q;
	logic              wild_q;
	logic              part_q;
	logic              hit;

	assign hit     = wild_q | (byte_q == data_byte);
	assign part    = part_q;
	// The partial match that this byte would complete, if this cell ends the pattern.
	assign end_hit = is_last & prev & hit;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= entry_byte;
			wild_q <= entry_wild;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= 1'b0;
		end else if (ctrl.clear) begin
			part_q <= 1'b0;
		end else if (ctrl.scan) begin
			part_q <= prev & hit;
		end
	end

endmodule

// File: src/wbps_out_buf.sv
module wbps_out_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [wbps_pkg::POS_W-1:0] push_data,
	output logic                      space,
	wbps_out_if.source                result
);
	import wbps_pkg::*;

	logic [POS_W-1:0] out_q;
	logic [POS_W-1:0] skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             pop;

	assign pop                = out_valid_q & result.ready;
	assign space              = ~skid_valid_q;
	assign result.valid       = out_valid_q;
	assign result.match_start = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end
		if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// File: src/wbps_checker.sv
module wbps_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [1:0]                 in_func,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [wbps_pkg::POS_W-1:0] out_match_start
);
	import wbps_pkg::*;

	// A result is never dropped while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_match_start))
		else $error("result payload changed while stalled");

	// A new result only follows a transfer on the item channel.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an item transfer");

	// Loads and restarts never produce a result.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func != FUNC_SCAN && !out_valid |=> !out_valid)
		else $error("result from a non-scan item");

	// With nothing buffered, the block always takes an item.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("item channel stalled with empty output");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (item.valid),
	.in_ready        (item.ready),
	.in_func         (item.func),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.out_match_start (result.match_start)
);
